// ===== design/qte_pkg.sv =====
// Package for the quaternion to Euler angle converter.
// Holds the shared widths, fixed-point constants and the CORDIC arctangent table.
// No dependencies.
`default_nettype none

package qte_pkg;

  // Field widths of the stream payloads.
  localparam int unsigned QW       = 16;   // quaternion component
  localparam int unsigned ANG_W    = 16;   // roll and yaw
  localparam int unsigned PITCH_W  = 15;   // pitch
  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 48;

  // Internal datapath widths.
  localparam int unsigned PROD_W = 32;     // one 16x16 product
  localparam int unsigned SUM_W  = 35;     // Q28 sine and cosine terms
  localparam int unsigned CW     = 37;     // CORDIC x and y
  localparam int unsigned ZW     = 35;     // CORDIC angle in Q30
  localparam int unsigned RAD_W  = 57;     // radicand 2^56 - s^2
  localparam int unsigned ROOT_W = 29;     // square root of the radicand
  localparam int unsigned RND_W  = ZW - 17; // angle after the Q30 to Q13 step

  // Default CORDIC depth; the table covers at most ATAN_LEN stages.
  localparam int unsigned CORDIC_STAGES_DEF = 16;
  localparam int unsigned ATAN_LEN = 24;

  // Fixed-point constants.
  localparam logic signed [SUM_W-1:0] ONE_Q28  = SUM_W'(64'sd268435456);
  localparam logic signed [ZW-1:0]    PI_Q30   = ZW'(64'sd3373259426);
  localparam logic signed [RND_W-1:0] ANGLE_MAX   = RND_W'(25736);
  localparam logic signed [RND_W-1:0] HALF_PI_Q13 = RND_W'(12868);
  localparam logic signed [PITCH_W-1:0] PITCH_SAT = PITCH_W'(12861);

  // Vector state handed from one CORDIC cell to the next.
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_vec_t;

  // Partial square root handed from one root cell to the next.
  typedef struct packed {
    logic [RAD_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } isqrt_t;

  // atan(2^-i) in Q30.
  function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] idx);
    logic signed [ZW-1:0] v;
    unique case (idx)
      5'd0:  v = ZW'(843314857);
      5'd1:  v = ZW'(497837829);
      5'd2:  v = ZW'(263043837);
      5'd3:  v = ZW'(133525159);
      5'd4:  v = ZW'(67021687);
      5'd5:  v = ZW'(33543516);
      5'd6:  v = ZW'(16775851);
      5'd7:  v = ZW'(8388437);
      5'd8:  v = ZW'(4194283);
      5'd9:  v = ZW'(2097149);
      5'd10: v = ZW'(1048576);
      5'd11: v = ZW'(524288);
      5'd12: v = ZW'(262144);
      5'd13: v = ZW'(131072);
      5'd14: v = ZW'(65536);
      5'd15: v = ZW'(32768);
      5'd16: v = ZW'(16384);
      5'd17: v = ZW'(8192);
      5'd18: v = ZW'(4096);
      5'd19: v = ZW'(2048);
      5'd20: v = ZW'(1024);
      5'd21: v = ZW'(512);
      5'd22: v = ZW'(256);
      5'd23: v = ZW'(128);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== design/qte_isqrt_cell.sv =====
// One cell of the square-root chain: decides one root bit per cycle while ce_i is high.
// Depends on qte_pkg.
`default_nettype none

module qte_isqrt_cell #(
  parameter int unsigned BIT = 0
) (
  input  wire logic            clk_i,
  input  wire logic            ce_i,
  input  wire qte_pkg::isqrt_t st_i,
  output qte_pkg::isqrt_t      st_o
);
  import qte_pkg::*;

  localparam int unsigned TW = RAD_W + 2;

  logic [TW-1:0] trial;
  isqrt_t        st_d, st_q;

  // Setting this bit adds 2*root*2^BIT + 2^(2*BIT) to the square.
  always_comb begin
    trial = (TW'(st_i.root) << (BIT + 1)) + (TW'(1) << (2 * BIT));
    st_d  = st_i;
    if (TW'(st_i.rem) >= trial) begin
      st_d.rem  = st_i.rem - trial[RAD_W-1:0];
      st_d.root = st_i.root | (ROOT_W'(1) << BIT);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      st_q <= st_d;
    end
  end

  assign st_o = st_q;

endmodule

`default_nettype wire

// ===== design/qte_cordic_cell.sv =====
// One vectoring CORDIC cell: a micro-rotation by atan(2^-STAGE) per cycle while ce_i is high.
// Depends on qte_pkg.
`default_nettype none

module qte_cordic_cell #(
  parameter int unsigned STAGE = 0
) (
  input  wire logic                 clk_i,
  input  wire logic                 ce_i,
  input  wire qte_pkg::cordic_vec_t v_i,
  output qte_pkg::cordic_vec_t      v_o
);
  import qte_pkg::*;

  logic signed [CW-1:0] xs, ys;
  logic signed [ZW-1:0] ang;
  cordic_vec_t          v_d, v_q;

  // Rotate against the sign of y; shifts round toward minus infinity.
  always_comb begin
    xs  = v_i.x >>> STAGE;
    ys  = v_i.y >>> STAGE;
    ang = atan_q30(5'(STAGE));
    if (v_i.y[CW-1]) begin
      v_d.x = v_i.x - ys;
      v_d.y = v_i.y + xs;
      v_d.z = v_i.z - ang;
    end else begin
      v_d.x = v_i.x + ys;
      v_d.y = v_i.y - xs;
      v_d.z = v_i.z + ang;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      v_q <= v_d;
    end
  end

  assign v_o = v_q;

endmodule

`default_nettype wire

// ===== design/qte_atan2.sv =====
// Pipelined atan2: pre-rotation, a chain of CORDIC cells, rounding and clamp.
// Depends on qte_pkg and qte_cordic_cell.
`default_nettype none

module qte_atan2 #(
  parameter int unsigned STAGES = qte_pkg::CORDIC_STAGES_DEF,
  parameter int unsigned OUT_W  = qte_pkg::ANG_W,
  parameter logic signed [qte_pkg::RND_W-1:0] LIM = qte_pkg::ANGLE_MAX
) (
  input  wire logic                           clk_i,
  input  wire logic                           ce_i,
  input  wire logic signed [qte_pkg::CW-1:0]  y_i,
  input  wire logic signed [qte_pkg::CW-1:0]  x_i,
  output logic signed [OUT_W-1:0]             ang_o
);
  import qte_pkg::*;

  cordic_vec_t          chain [STAGES+1];
  cordic_vec_t          pre_d, pre_q;
  logic [STAGES:0]      zero_q;
  logic signed [RND_W-1:0] rnd;
  logic signed [OUT_W-1:0] ang_d, ang_q;

  // Fold the left half-plane over by plus or minus pi.
  always_comb begin
    pre_d.x = x_i;
    pre_d.y = y_i;
    pre_d.z = '0;
    if (x_i[CW-1]) begin
      pre_d.x = -x_i;
      pre_d.y = -y_i;
      pre_d.z = y_i[CW-1] ? -PI_Q30 : PI_Q30;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      pre_q     <= pre_d;
      zero_q[0] <= (x_i == '0) && (y_i == '0);
    end
  end

  assign chain[0] = pre_q;

  // Rotation cells; the zero-vector flag travels alongside.
  for (genvar g = 0; g < STAGES; g++) begin : g_cell
    qte_cordic_cell #(.STAGE(g)) u_cell (
      .clk_i (clk_i),
      .ce_i  (ce_i),
      .v_i   (chain[g]),
      .v_o   (chain[g+1])
    );

    always_ff @(posedge clk_i) begin
      if (ce_i) begin
        zero_q[g+1] <= zero_q[g];
      end
    end
  end

  // Q30 to Q13 with rounding, then clamp; a zero vector gives zero.
  always_comb begin
    rnd = RND_W'((chain[STAGES].z + ZW'(65536)) >>> 17);
    if (zero_q[STAGES]) begin
      ang_d = '0;
    end else if (rnd > LIM) begin
      ang_d = OUT_W'(LIM);
    end else if (rnd < -LIM) begin
      ang_d = OUT_W'(-LIM);
    end else begin
      ang_d = OUT_W'(rnd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      ang_q <= ang_d;
    end
  end

  assign ang_o = ang_q;

endmodule

`default_nettype wire

// ===== design/quaternion_to_euler.sv =====
// Top level of the quaternion to Euler angle converter (roll, pitch, yaw).
// Depends on qte_pkg, qte_isqrt_cell and qte_atan2.
//
//   channel   dir  width  contents
//   s_axis    in   64     qx [15:0], qy [31:16], qz [47:32], qw [63:48]
//   m_axis    out  48     roll_angle [15:0], pitch_angle [30:16], yaw_angle [46:31]
//
// One request per cycle is accepted. Data passes through two product/sum
// stages, one squaring stage, 29 square-root cells, the CORDIC chain of
// CORDIC_STAGES cells plus pre-rotation and rounding, and the output
// register. A single held result does not stop intake; the pipeline
// pauses only while the skid entry is full. Reset clears only the valid
// bits.
`default_nettype none

module quaternion_to_euler #(
  parameter int unsigned CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  wire logic [qte_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // qx, qy, qz, qw
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  output logic [qte_pkg::OUT_TDATA_W-1:0]          m_axis_tdata   // roll, pitch, yaw, pad
);
  import qte_pkg::*;

  localparam int unsigned ISQ_N   = ROOT_W;
  localparam int unsigned DL_N    = ISQ_N + 1;
  localparam int unsigned ATAN_L  = CORDIC_STAGES + 2;
  localparam int unsigned LAT     = 3 + ISQ_N + ATAN_L;

  logic ce;

  // Stage 1: the nine products.
  logic signed [QW-1:0] qx, qy, qz, qw;
  logic signed [PROD_W-1:0] wx_q, yz_q, xx_q, yy_q, wy_q, zx_q, wz_q, xy_q, zz_q;

  assign qx = s_axis_tdata[QW-1:0];
  assign qy = s_axis_tdata[2*QW-1:QW];
  assign qz = s_axis_tdata[3*QW-1:2*QW];
  assign qw = s_axis_tdata[4*QW-1:3*QW];

  always_ff @(posedge clk_i) begin
    if (ce) begin
      wx_q <= PROD_W'(qw) * PROD_W'(qx);
      yz_q <= PROD_W'(qy) * PROD_W'(qz);
      xx_q <= PROD_W'(qx) * PROD_W'(qx);
      yy_q <= PROD_W'(qy) * PROD_W'(qy);
      wy_q <= PROD_W'(qw) * PROD_W'(qy);
      zx_q <= PROD_W'(qz) * PROD_W'(qx);
      wz_q <= PROD_W'(qw) * PROD_W'(qz);
      xy_q <= PROD_W'(qx) * PROD_W'(qy);
      zz_q <= PROD_W'(qz) * PROD_W'(qz);
    end
  end

  // Stage 2: sine and cosine terms in Q28.
  logic signed [SUM_W-1:0] sinr_q, cosr_q, sinp_q, siny_q, cosy_q;

  always_ff @(posedge clk_i) begin
    if (ce) begin
      sinr_q <= (SUM_W'(wx_q) + SUM_W'(yz_q)) <<< 1;
      cosr_q <= ONE_Q28 - ((SUM_W'(xx_q) + SUM_W'(yy_q)) <<< 1);
      sinp_q <= (SUM_W'(wy_q) - SUM_W'(zx_q)) <<< 1;
      siny_q <= (SUM_W'(wz_q) + SUM_W'(xy_q)) <<< 1;
      cosy_q <= ONE_Q28 - ((SUM_W'(yy_q) + SUM_W'(zz_q)) <<< 1);
    end
  end

  // Stage 3: radicand 2^56 - s^2 for the pitch cosine.
  logic [RAD_W-2:0] sabs, ssq;
  logic [ROOT_W-2:0] sabs_lo;
  isqrt_t isq [ISQ_N+1];

  always_comb begin
    sabs    = (RAD_W-1)'(sinp_q[SUM_W-1] ? -sinp_q : sinp_q);
    sabs_lo = sabs[ROOT_W-2:0];
    ssq     = (RAD_W-1)'(sabs_lo) * (RAD_W-1)'(sabs_lo);
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      isq[0].rem  <= (RAD_W'(1) << (RAD_W - 1)) - RAD_W'(ssq);
      isq[0].root <= '0;
    end
  end

  // Square-root chain, most significant root bit first.
  for (genvar g = 0; g < ISQ_N; g++) begin : g_isq
    qte_isqrt_cell #(.BIT(ISQ_N - 1 - g)) u_cell (
      .clk_i (clk_i),
      .ce_i  (ce),
      .st_i  (isq[g]),
      .st_o  (isq[g+1])
    );
  end

  // Delay line that keeps the other terms level with the root chain.
  logic signed [SUM_W-1:0] dl_sinr [DL_N];
  logic signed [SUM_W-1:0] dl_cosr [DL_N];
  logic signed [SUM_W-1:0] dl_siny [DL_N];
  logic signed [SUM_W-1:0] dl_cosy [DL_N];
  logic signed [SUM_W-1:0] dl_sinp [DL_N];
  logic [DL_N-1:0] dl_satp, dl_satn;

  always_ff @(posedge clk_i) begin
    if (ce) begin
      dl_sinr[0] <= sinr_q;
      dl_cosr[0] <= cosr_q;
      dl_siny[0] <= siny_q;
      dl_cosy[0] <= cosy_q;
      dl_sinp[0] <= sinp_q;
      dl_satp[0] <= (sinp_q >= ONE_Q28);
      dl_satn[0] <= (sinp_q <= -ONE_Q28);
      for (int i = 1; i < DL_N; i++) begin
        dl_sinr[i] <= dl_sinr[i-1];
        dl_cosr[i] <= dl_cosr[i-1];
        dl_siny[i] <= dl_siny[i-1];
        dl_cosy[i] <= dl_cosy[i-1];
        dl_sinp[i] <= dl_sinp[i-1];
        dl_satp[i] <= dl_satp[i-1];
        dl_satn[i] <= dl_satn[i-1];
      end
    end
  end

  // The three arctangents run in lockstep.
  logic signed [ANG_W-1:0]   roll, yaw;
  logic signed [PITCH_W-1:0] pitch_raw;

  qte_atan2 #(.STAGES(CORDIC_STAGES), .OUT_W(ANG_W), .LIM(ANGLE_MAX)) u_roll (
    .clk_i (clk_i),
    .ce_i  (ce),
    .y_i   (CW'(dl_sinr[DL_N-1])),
    .x_i   (CW'(dl_cosr[DL_N-1])),
    .ang_o (roll)
  );

  qte_atan2 #(.STAGES(CORDIC_STAGES), .OUT_W(ANG_W), .LIM(ANGLE_MAX)) u_yaw (
    .clk_i (clk_i),
    .ce_i  (ce),
    .y_i   (CW'(dl_siny[DL_N-1])),
    .x_i   (CW'(dl_cosy[DL_N-1])),
    .ang_o (yaw)
  );

  qte_atan2 #(.STAGES(CORDIC_STAGES), .OUT_W(PITCH_W), .LIM(HALF_PI_Q13)) u_pitch (
    .clk_i (clk_i),
    .ce_i  (ce),
    .y_i   (CW'(dl_sinp[DL_N-1])),
    .x_i   (CW'(isq[ISQ_N].root)),
    .ang_o (pitch_raw)
  );

  // Saturation flags follow the pitch CORDIC.
  logic [ATAN_L-1:0] sp_q, sn_q;

  always_ff @(posedge clk_i) begin
    if (ce) begin
      sp_q <= {sp_q[ATAN_L-2:0], dl_satp[DL_N-1]};
      sn_q <= {sn_q[ATAN_L-2:0], dl_satn[DL_N-1]};
    end
  end

  logic signed [PITCH_W-1:0] pitch;

  always_comb begin
    priority if (sp_q[ATAN_L-1]) begin
      pitch = PITCH_SAT;
    end else if (sn_q[ATAN_L-1]) begin
      pitch = -PITCH_SAT;
    end else begin
      pitch = pitch_raw;
    end
  end

  // Valid bits for every stage.
  logic [LAT-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ce) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
    end
  end

  // Output register with one skid entry.
  logic [OUT_TDATA_W-1:0] res, out_q, skid_q;
  logic out_vq, skid_vq, push, take;

  assign res  = {1'b0, yaw, pitch, roll};
  assign ce   = !skid_vq;
  assign push = ce && vld_q[LAT-1];
  assign take = !out_vq || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vq  <= 1'b0;
      skid_vq <= 1'b0;
    end else if (take) begin
      out_vq  <= skid_vq || push;
      skid_vq <= 1'b0;
    end else if (push) begin
      skid_vq <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= skid_vq ? skid_q : res;
    end else if (push) begin
      skid_q <= res;
    end
  end

  assign s_axis_tready = ce;
  assign m_axis_tvalid = out_vq;
  assign m_axis_tdata  = out_q;

endmodule

`default_nettype wire
